// ----- hw/rtl/gpc_pkg.sv -----
// ---------------------------------------------------------------------------
// gpc_pkg
// Shared sizes and control types for the grid route counter.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gpc_pkg;

  // grid size handled by the counter
  localparam int unsigned ROWS  = 8;
  localparam int unsigned COLS  = 8;
  // count fields carried in every result
  localparam int unsigned NCOL  = 8;
  localparam int unsigned CNT_W = 12;
  localparam int unsigned ROW_W = (ROWS > 2) ? $clog2(ROWS) : 1;

  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  typedef logic [CNT_W-1:0] count_t;
  typedef logic [ROW_W-1:0] row_idx_t;

  // row position, common to all cells
  typedef struct packed {
    logic first_row;
    logic second_row;
  } row_ctrl_t;

  // fixed column position of one cell
  typedef struct packed {
    logic enabled;
    logic is_col0;
    logic is_col1;
  } col_cfg_t;

endpackage

`default_nettype wire

// ----- hw/rtl/gpc_if.sv -----
// ---------------------------------------------------------------------------
// gpc_in_if / gpc_out_if
// Valid/ready channels for grid rows and for row count results.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface gpc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] blocked_bits;
  logic       last_row;

  modport source (output valid, blocked_bits, last_row, input ready);
  modport sink   (input valid, blocked_bits, last_row, output ready);
endinterface

interface gpc_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] count_0;
  logic [11:0] count_1;
  logic [11:0] count_2;
  logic [11:0] count_3;
  logic [11:0] count_4;
  logic [11:0] count_5;
  logic [11:0] count_6;
  logic [11:0] count_7;
  logic        row_done_last;

  modport source (output valid, count_0, count_1, count_2, count_3, count_4, count_5,
                  count_6, count_7, row_done_last, input ready);
  modport sink   (input valid, count_0, count_1, count_2, count_3, count_4, count_5,
                  count_6, count_7, row_done_last, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/gpc_cell.sv -----
// ---------------------------------------------------------------------------
// gpc_cell
// One column of the counter: keeps the count above and forms this row's count.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gpc_cell (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              advance,
  input  wire logic              open,
  input  wire gpc_pkg::row_ctrl_t ctrl,
  input  wire gpc_pkg::col_cfg_t  col,
  input  wire gpc_pkg::count_t    left_count,
  output gpc_pkg::count_t         count
);

  gpc_pkg::count_t          prior;
  logic [gpc_pkg::CNT_W:0]  sum;

  // sum of above and left, with a carry bit for saturation
  assign sum = {1'b0, prior} + {1'b0, left_count};

  // count of this column for the current row
  always_comb begin
    if (!col.enabled || !open) begin
      count = '0;
    end else if (ctrl.first_row) begin
      if (col.is_col0) begin
        count = '0;
      end else begin
        count = (col.is_col1 || (left_count != '0)) ? gpc_pkg::CNT_W'(1) : '0;
      end
    end else if (col.is_col0) begin
      count = (ctrl.second_row || (prior != '0)) ? gpc_pkg::CNT_W'(1) : '0;
    end else if (sum[gpc_pkg::CNT_W]) begin
      count = gpc_pkg::COUNT_MAX;
    end else begin
      count = sum[gpc_pkg::CNT_W-1:0];
    end
  end

  // row above, replaced on every transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      prior <= '0;
    end else if (advance) begin
      prior <= count;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/grid_path_count_with_obstacles.sv -----
// ---------------------------------------------------------------------------
// grid_path_count_with_obstacles
// Route counter over a grid with blocked cells, one row per transaction.
// ---------------------------------------------------------------------------
// Usage:
//   in_ch carries one grid row per transaction: blocked_bits (bit c blocks
//   column c) and last_row, which closes the grid. out_ch returns one
//   transaction per row with the eight column counts and row_done_last.
//   A row that reaches the grid's row limit closes the grid even without
//   last_row.
//   out_ch.valid rises in the cycle after the input transaction.
//   Throughput is one row per cycle while the receiver takes results: the
//   column cells form a left-to-right chain that settles within the cycle,
//   and each cell keeps its count for the next row.
//   Reset clears the kept counts, the row number and the output valid flag;
//   the first row after reset starts a new grid.
//   When the receiver stalls, the result stays in the output register and
//   in_ch.ready drops until it is taken; a new row is accepted in the same
//   cycle the waiting result leaves.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module grid_path_count_with_obstacles (
  input  wire logic  clk,
  input  wire logic  rst,
  gpc_in_if.sink     in_ch,
  gpc_out_if.source  out_ch
);

  logic                               accept;
  logic                               final_row;
  gpc_pkg::row_idx_t                  row_index;
  gpc_pkg::row_ctrl_t                 ctrl;
  gpc_pkg::count_t [gpc_pkg::NCOL-1:0] cur;
  gpc_pkg::count_t [gpc_pkg::NCOL-1:0] out_counts;
  logic                               out_last;
  logic                               out_valid;

  // input handshake
  assign in_ch.ready = !out_valid || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  // row position within the grid
  assign ctrl.first_row  = (row_index == '0);
  assign ctrl.second_row = (row_index == gpc_pkg::ROW_W'(1));
  assign final_row = in_ch.last_row || (row_index == gpc_pkg::ROW_W'(gpc_pkg::ROWS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      row_index <= '0;
    end else if (accept) begin
      row_index <= final_row ? '0 : row_index + gpc_pkg::ROW_W'(1);
    end
  end

  // chain of column cells
  for (genvar c = 0; c < gpc_pkg::NCOL; c++) begin : g_cell
    gpc_pkg::col_cfg_t col;
    gpc_pkg::count_t   left;

    assign col.enabled = (c < gpc_pkg::COLS);
    assign col.is_col0 = (c == 0);
    assign col.is_col1 = (c == 1);

    if (c == 0) begin : g_edge
      assign left = '0;
    end else begin : g_inner
      assign left = cur[c-1];
    end

    gpc_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .advance    (accept),
      .open       (!in_ch.blocked_bits[c]),
      .ctrl       (ctrl),
      .col        (col),
      .left_count (left),
      .count      (cur[c])
    );
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_counts <= cur;
      out_last   <= final_row;
    end
  end

  assign out_ch.valid         = out_valid;
  assign out_ch.count_0       = out_counts[0];
  assign out_ch.count_1       = out_counts[1];
  assign out_ch.count_2       = out_counts[2];
  assign out_ch.count_3       = out_counts[3];
  assign out_ch.count_4       = out_counts[4];
  assign out_ch.count_5       = out_counts[5];
  assign out_ch.count_6       = out_counts[6];
  assign out_ch.count_7       = out_counts[7];
  assign out_ch.row_done_last = out_last;

`ifndef SYNTHESIS
  // a transaction always leaves a result in the output register
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("no result after input transaction");

  // a closing row restarts the grid
  a_grid_restart: assert property (@(posedge clk) disable iff (rst)
    (accept && final_row) |=> (row_index == '0))
    else $error("row number not cleared after final row");

  // the origin always reports zero
  a_origin_zero: assert property (@(posedge clk) disable iff (rst)
    (accept && ctrl.first_row) |=> (out_counts[0] == '0))
    else $error("origin count not zero");

  // row_done_last tracks the row position
  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    (accept && (row_index == gpc_pkg::ROW_W'(gpc_pkg::ROWS - 1))) |=> out_last)
    else $error("row limit not flagged as final");
`endif

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the grid route counter. Grid rows are queued up
// front and sent by a clocked driver with random gaps. A monitor predicts
// the counts of every accepted row and checks each returned transaction
// field by field, while the receiver stalls at random.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned RAND_ROWS   = 1300;
  localparam int unsigned STALL_AT    = 300;
  localparam int unsigned STALL_LEN   = 150;

  // one queued grid row; drain_first makes the sender wait for all results
  typedef struct packed {
    logic [7:0] blocked;
    logic       last;
    logic       drain_first;
  } grid_row_t;

  // counts of one row as returned by the block
  typedef struct packed {
    gpc_pkg::count_t [gpc_pkg::NCOL-1:0] cnt;
    logic                                row_last;
  } row_counts_t;

  logic clk;
  logic rst;

  gpc_in_if  in_if ();
  gpc_out_if out_if ();

  grid_path_count_with_obstacles u_top (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  grid_row_t   row_queue[$];
  row_counts_t count_queue[$];

  // predictor state: counts of the previous row and position in the grid
  gpc_pkg::count_t   route_prior [gpc_pkg::NCOL];
  gpc_pkg::row_idx_t route_row;

  int unsigned cycle_cnt;
  int unsigned err_cnt;
  int unsigned rows_sent;
  int unsigned rows_back;
  int unsigned send_wait;
  int unsigned hold_left;
  bit          long_hold_done;
  int unsigned grids_closed;
  int unsigned limit_closes;
  int unsigned peak_count;

  grid_row_t   next_row;
  row_counts_t seen_counts;
  row_counts_t want_counts;
  row_counts_t new_counts;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // gap length: none in calm stretches, otherwise mostly short, a few long
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if ((cycle_cnt / 128) % 4 == 0) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic gpc_pkg::count_t sat_sum(input gpc_pkg::count_t a,
                                              input gpc_pkg::count_t b);
    logic [gpc_pkg::CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > {1'b0, gpc_pkg::COUNT_MAX}) ? gpc_pkg::COUNT_MAX : s[gpc_pkg::CNT_W-1:0];
  endfunction

  // route counts of one row from the previous row and the blocked bits
  task automatic predict_row(input logic [7:0] blk, input logic last,
                             output row_counts_t res);
    gpc_pkg::count_t   cur [gpc_pkg::NCOL];
    gpc_pkg::row_idx_t r;
    logic              closes;
    r = route_row;
    for (int c = 0; c < gpc_pkg::NCOL; c++) begin
      if (c >= gpc_pkg::COLS || blk[c]) begin
        cur[c] = '0;
      end else if (r == 0 && c == 0) begin
        cur[c] = '0;
      end else if (r == 0) begin
        cur[c] = (c == 1 || cur[c-1] != 0) ? gpc_pkg::count_t'(1) : gpc_pkg::count_t'(0);
      end else if (c == 0) begin
        cur[c] = (r == 1 || route_prior[0] != 0) ? gpc_pkg::count_t'(1)
                                                  : gpc_pkg::count_t'(0);
      end else begin
        cur[c] = sat_sum(route_prior[c], cur[c-1]);
      end
    end
    closes = last || (r >= gpc_pkg::ROWS - 1);
    if (closes) grids_closed++;
    if (closes && !last) limit_closes++;
    for (int c = 0; c < gpc_pkg::NCOL; c++) begin
      route_prior[c] = cur[c];
      res.cnt[c] = cur[c];
      if (cur[c] > peak_count) peak_count = cur[c];
    end
    res.row_last = closes;
    route_row = closes ? gpc_pkg::row_idx_t'(0) : gpc_pkg::row_idx_t'(r + 1);
  endtask

  task automatic report_mismatch(input string field, input int unsigned got_v,
                                 input int unsigned want_v);
    $display("MISMATCH result %0d %s: got %0d, want %0d", rows_back, field, got_v, want_v);
    err_cnt++;
  endtask

  task automatic add_row(input logic [7:0] blk, input logic last, input logic drain);
    grid_row_t g;
    g.blocked     = blk;
    g.last        = last;
    g.drain_first = drain;
    row_queue.push_back(g);
  endtask

  // blocked-bit pattern with a random density
  function automatic logic [7:0] pick_blocked();
    int unsigned mode;
    logic [7:0]  b;
    mode = $urandom_range(0, 99);
    b = '0;
    if (mode < 20) return 8'h00;
    if (mode < 85) begin
      for (int c = 0; c < 8; c++) begin
        b[c] = (mode < 70) ? ($urandom_range(0, 7) == 0) : ($urandom_range(0, 3) == 0);
      end
      return b;
    end
    return 8'($urandom_range(0, 255));
  endfunction

  // row driver
  always @(posedge clk) begin
    if (rst) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) rows_sent++;
      if (!in_if.valid || in_if.ready) begin
        if (send_wait > 0) begin
          send_wait--;
          in_if.valid <= 1'b0;
        end else if (row_queue.size() == 0 ||
                     (row_queue[0].drain_first && rows_sent != rows_back)) begin
          in_if.valid <= 1'b0;
        end else begin
          next_row = row_queue.pop_front();
          in_if.blocked_bits <= next_row.blocked;
          in_if.last_row     <= next_row.last;
          in_if.valid        <= 1'b1;
          send_wait = pick_gap();
        end
      end
    end
  end

  // receiver ready, with one long hold-off once results are flowing
  always @(posedge clk) begin
    if (rst) begin
      out_if.ready <= 1'b0;
    end else begin
      if (hold_left > 0) begin
        hold_left--;
      end else if (!long_hold_done && rows_back >= STALL_AT) begin
        long_hold_done = 1'b1;
        hold_left = STALL_LEN;
      end else if ((out_if.valid && out_if.ready) || $urandom_range(0, 15) == 0) begin
        hold_left = pick_gap();
      end
      out_if.ready <= (hold_left == 0);
    end
  end

  // monitor: check returned rows, then predict newly accepted rows
  always @(posedge clk) begin
    if (!rst) begin
      if (out_if.valid && out_if.ready) begin
        seen_counts.cnt[0]  = out_if.count_0;
        seen_counts.cnt[1]  = out_if.count_1;
        seen_counts.cnt[2]  = out_if.count_2;
        seen_counts.cnt[3]  = out_if.count_3;
        seen_counts.cnt[4]  = out_if.count_4;
        seen_counts.cnt[5]  = out_if.count_5;
        seen_counts.cnt[6]  = out_if.count_6;
        seen_counts.cnt[7]  = out_if.count_7;
        seen_counts.row_last = out_if.row_done_last;
        if (count_queue.size() == 0) begin
          report_mismatch("transaction with no row pending", 1, 0);
        end else begin
          want_counts = count_queue.pop_front();
          for (int c = 0; c < gpc_pkg::NCOL; c++) begin
            if (seen_counts.cnt[c] !== want_counts.cnt[c])
              report_mismatch($sformatf("count_%0d", c), seen_counts.cnt[c], want_counts.cnt[c]);
          end
          if (seen_counts.row_last !== want_counts.row_last)
            report_mismatch("row_done_last", seen_counts.row_last, want_counts.row_last);
        end
        rows_back <= rows_back + 1;
      end
      if (in_if.valid && in_if.ready) begin
        predict_row(in_if.blocked_bits, in_if.last_row, new_counts);
        count_queue.push_back(new_counts);
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               count_queue.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin
    int unsigned n_rand;
    int unsigned len;
    int unsigned roll;
    bit          drain;
    logic        last;

    rst = 1'b1;
    in_if.valid        = 1'b0;
    in_if.blocked_bits = '0;
    in_if.last_row     = 1'b0;
    out_if.ready       = 1'b0;
    for (int c = 0; c < gpc_pkg::NCOL; c++) route_prior[c] = '0;
    route_row = '0;

    // open 8x8 grid reaches the largest count
    for (int r = 0; r < 8; r++) add_row(8'h00, r == 7, 1'b0);
    // blocked origin still feeds its neighbors, single-row grid
    add_row(8'h01, 1'b1, 1'b0);
    // fully blocked single row
    add_row(8'hFF, 1'b1, 1'b0);
    // break in the first row, then a blocked first column cuts column 0
    add_row(8'h04, 1'b0, 1'b1);
    add_row(8'h81, 1'b0, 1'b0);
    add_row(8'h00, 1'b1, 1'b0);
    // no last_row: the row limit closes the grid, the next row starts anew
    for (int r = 0; r < 9; r++) add_row(8'h00, r == 8, 1'b0);

    // random grids, mostly well formed, some broken sequences
    n_rand = 0;
    drain = 1'b1;
    while (n_rand < RAND_ROWS) begin
      roll = $urandom_range(0, 99);
      if (roll < 85) begin
        len = $urandom_range(0, 1) ? 8 : $urandom_range(1, 7);
        for (int r = 0; r < len; r++) begin
          last = (r == len - 1) && (len < 8 || $urandom_range(0, 1));
          add_row(pick_blocked(), last, drain && r == 0);
        end
      end else begin
        len = $urandom_range(1, 12);
        for (int r = 0; r < len; r++) begin
          last = (r == len - 1) || ($urandom_range(0, 3) == 0);
          add_row(8'($urandom_range(0, 255)), last, 1'b0);
        end
      end
      n_rand += len;
      drain = ($urandom_range(0, 99) < 3);
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk); while (row_queue.size() != 0 || in_if.valid);
    do @(negedge clk); while (count_queue.size() != 0);
    repeat (8) @(negedge clk);

    $display("Rows checked: %0d in %0d grids, %0d closed by the row limit",
             rows_back, grids_closed, limit_closes);
    $display("Largest route count seen: %0d, long receiver stall %0s",
             peak_count, long_hold_done ? "done" : "not reached");
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
